// ===== hdl/psh_pkg.sv =====
// Shared types, field positions and codes of the pressure sensor health monitor.
`default_nettype none

package psh_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PRESS_W    = 24;
    localparam int unsigned TEMP_W     = 16;
    localparam int unsigned LIMIT_P_W  = 23;
    localparam int unsigned SPREAD_W   = 24;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned OUTCOME_W  = 3;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_DATA_W = 72;

    localparam int unsigned IN_NOW_LSB     = 0;
    localparam int unsigned IN_READ_OK_BIT = 32;
    localparam int unsigned IN_FINITE_BIT  = 33;
    localparam int unsigned IN_PRESS_LSB   = 34;
    localparam int unsigned IN_TEMP_LSB    = 58;
    localparam int unsigned IN_PROBE_BIT   = 74;
    localparam int unsigned IN_ACTION_BIT  = 0;

    localparam int unsigned OUT_ACC_BIT     = 0;
    localparam int unsigned OUT_OC_LSB      = 1;
    localparam int unsigned OUT_PROBED_BIT  = 4;
    localparam int unsigned OUT_HEALTHY_BIT = 5;
    localparam int unsigned OUT_JITTER_BIT  = 6;
    localparam int unsigned OUT_SPREAD_LSB  = 7;
    localparam int unsigned OUT_PRESS_LSB   = 31;
    localparam int unsigned OUT_TEMP_LSB    = 55;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST     = -16'sd500;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST    = 16'sd6000;
    localparam logic [LIMIT_P_W-1:0]     PRESS_LOW_RST    = 23'd3000;
    localparam logic [LIMIT_P_W-1:0]     PRESS_HIGH_RST   = 23'd400000;
    localparam logic [SPREAD_W-1:0]      JITTER_LIMIT_RST = 24'd150;
    localparam logic [COUNT_W-1:0]       UNHEALTHY_RST    = 8'd3;
    localparam logic [COUNT_W-1:0]       REPROBE_RST      = 8'd10;
    localparam logic [TIME_W-1:0]        REPROBE_GAP_RST  = 32'd2000;
    localparam logic [COUNT_W-1:0]       FAIL_MAX         = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_LOW,
        CFG_TEMP_HIGH,
        CFG_PRESS_LOW,
        CFG_PRESS_HIGH,
        CFG_JITTER_LIMIT,
        CFG_UNHEALTHY_AFTER,
        CFG_REPROBE_AFTER,
        CFG_REPROBE_GAP
    } t_cfg_idx;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_OK,
        OC_ABSENT,
        OC_READ_FAIL,
        OC_IMPLAUSIBLE,
        OC_JITTER
    } t_outcome;

    typedef enum logic [3:0] {
        C_TRUE,
        C_IN_VALID,
        C_ACTION,
        C_PRESENT,
        C_GAP_OK,
        C_READ_OK,
        C_REPROBE,
        C_PLAUS,
        C_SCAN_DONE,
        C_WROTE,
        C_WAS_FULL,
        C_JITTER,
        C_OUT_FREE
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_cond    cond;
        logic     sense;
        t_step    target;
        logic     load;
        logic     start;
        logic     probe;
        logic     bump;
        logic     wr;
        logic     scan_init;
        logic     scan_step;
        logic     jit_upd;
        logic     acc;
        logic     emit;
        logic     set_oc;
        t_outcome oc;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic action;
        logic present;
        logic gap_ok;
        logic read_ok;
        logic reprobe;
        logic plaus;
        logic scan_done;
        logic wrote;
        logic was_full;
        logic jitter;
        logic out_free;
    } t_flags;

endpackage

`default_nettype wire

// ===== hdl/psh_seq.sv =====
// Microcode sequencer: step counter, control store and condition select.
`default_nettype none

module psh_seq
    import psh_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_uop        o_uop,
    output logic        o_idle
);

    localparam t_step S_IDLE    = 5'd0;
    localparam t_step S_ACTION  = 5'd1;
    localparam t_step S_PRESENT = 5'd2;
    localparam t_step S_ABS_GAP = 5'd3;
    localparam t_step S_ABS_PRB = 5'd4;
    localparam t_step S_ABS_CHK = 5'd5;
    localparam t_step S_ABS_OUT = 5'd6;
    localparam t_step S_READ_OK = 5'd7;
    localparam t_step S_RD_FAIL = 5'd8;
    localparam t_step S_RD_GATE = 5'd9;
    localparam t_step S_RD_PRB  = 5'd10;
    localparam t_step S_PLAUS   = 5'd11;
    localparam t_step S_IMPL    = 5'd12;
    localparam t_step S_WRITE   = 5'd13;
    localparam t_step S_SPREAD  = 5'd14;
    localparam t_step S_SCAN    = 5'd15;
    localparam t_step S_CHK_WR  = 5'd16;
    localparam t_step S_CHK_FUL = 5'd17;
    localparam t_step S_JIT_UPD = 5'd18;
    localparam t_step S_CHK_JIT = 5'd19;
    localparam t_step S_REJECT  = 5'd20;
    localparam t_step S_ACCEPT  = 5'd21;
    localparam t_step S_EMIT    = 5'd22;
    localparam t_step S_BACK    = 5'd23;
    localparam t_step S_START   = 5'd24;

    function automatic t_uop f_rom(input t_step a);
        t_uop u;
        u = '0;
        case (a)
            S_IDLE: begin
                u.load = 1'b1; u.cond = C_IN_VALID; u.target = S_IDLE;
            end
            S_ACTION: begin
                u.cond = C_ACTION; u.sense = 1'b1; u.target = S_START;
            end
            S_PRESENT: begin
                u.cond = C_PRESENT; u.sense = 1'b1; u.target = S_READ_OK;
            end
            S_ABS_GAP: begin
                u.cond = C_GAP_OK; u.target = S_ABS_OUT;
            end
            S_ABS_PRB: begin
                u.probe = 1'b1;
            end
            S_ABS_CHK: begin
                u.cond = C_PRESENT; u.sense = 1'b1; u.target = S_READ_OK;
            end
            S_ABS_OUT: begin
                u.set_oc = 1'b1; u.oc = OC_ABSENT;
                u.sense = 1'b1; u.target = S_SPREAD;
            end
            S_READ_OK: begin
                u.cond = C_READ_OK; u.sense = 1'b1; u.target = S_PLAUS;
            end
            S_RD_FAIL: begin
                u.bump = 1'b1; u.set_oc = 1'b1; u.oc = OC_READ_FAIL;
            end
            S_RD_GATE: begin
                u.cond = C_REPROBE; u.target = S_SPREAD;
            end
            S_RD_PRB: begin
                u.probe = 1'b1; u.sense = 1'b1; u.target = S_SPREAD;
            end
            S_PLAUS: begin
                u.cond = C_PLAUS; u.sense = 1'b1; u.target = S_WRITE;
            end
            S_IMPL: begin
                u.bump = 1'b1; u.set_oc = 1'b1; u.oc = OC_IMPLAUSIBLE;
                u.sense = 1'b1; u.target = S_SPREAD;
            end
            S_WRITE: begin
                u.wr = 1'b1;
            end
            S_SPREAD: begin
                u.scan_init = 1'b1;
            end
            S_SCAN: begin
                u.scan_step = 1'b1; u.cond = C_SCAN_DONE; u.target = S_SCAN;
            end
            S_CHK_WR: begin
                u.cond = C_WROTE; u.target = S_EMIT;
            end
            S_CHK_FUL: begin
                u.cond = C_WAS_FULL; u.target = S_ACCEPT;
            end
            S_JIT_UPD: begin
                u.jit_upd = 1'b1;
            end
            S_CHK_JIT: begin
                u.cond = C_JITTER; u.target = S_ACCEPT;
            end
            S_REJECT: begin
                u.set_oc = 1'b1; u.oc = OC_JITTER;
                u.sense = 1'b1; u.target = S_EMIT;
            end
            S_ACCEPT: begin
                u.acc = 1'b1;
            end
            S_EMIT: begin
                u.emit = 1'b1; u.cond = C_OUT_FREE; u.target = S_EMIT;
            end
            S_BACK: begin
                u.sense = 1'b1; u.target = S_IDLE;
            end
            S_START: begin
                u.start = 1'b1; u.sense = 1'b1; u.target = S_SPREAD;
            end
            default: begin
                u.sense = 1'b1; u.target = S_IDLE;
            end
        endcase
        return u;
    endfunction

    t_step r_pc;
    t_step n_pc;
    logic  w_cond;

    assign o_uop  = f_rom(r_pc);
    assign o_idle = (r_pc == S_IDLE);

    always_comb begin
        case (o_uop.cond)
            C_TRUE:      w_cond = 1'b1;
            C_IN_VALID:  w_cond = i_flags.in_valid;
            C_ACTION:    w_cond = i_flags.action;
            C_PRESENT:   w_cond = i_flags.present;
            C_GAP_OK:    w_cond = i_flags.gap_ok;
            C_READ_OK:   w_cond = i_flags.read_ok;
            C_REPROBE:   w_cond = i_flags.reprobe;
            C_PLAUS:     w_cond = i_flags.plaus;
            C_SCAN_DONE: w_cond = i_flags.scan_done;
            C_WROTE:     w_cond = i_flags.wrote;
            C_WAS_FULL:  w_cond = i_flags.was_full;
            C_JITTER:    w_cond = i_flags.jitter;
            C_OUT_FREE:  w_cond = i_flags.out_free;
            default:     w_cond = 1'b0;
        endcase
    end

    always_comb begin
        if (w_cond == o_uop.sense) begin
            n_pc = o_uop.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/psh_dp.sv =====
// Datapath: limit registers, sensor state, sample window memory and result register.
`default_nettype none

module psh_dp
    import psh_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,
    input  wire t_uop                  i_uop,
    output t_flags                     o_flags,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int unsigned IDX_W  = $clog2(WINDOW_LEN);
    localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
    localparam logic [IDX_W-1:0]  POS_LAST  = IDX_W'(WINDOW_LEN - 1);

    logic signed [TEMP_W-1:0] r_temp_lo;
    logic signed [TEMP_W-1:0] r_temp_hi;
    logic [LIMIT_P_W-1:0]     r_press_lo;
    logic [LIMIT_P_W-1:0]     r_press_hi;
    logic [SPREAD_W-1:0]      r_jit_lim;
    logic [COUNT_W-1:0]       r_unhealthy_after;
    logic [COUNT_W-1:0]       r_reprobe_after;
    logic [TIME_W-1:0]        r_gap;

    logic                      r_action;
    logic [TIME_W-1:0]         r_now;
    logic                      r_read_ok;
    logic                      r_finite;
    logic signed [PRESS_W-1:0] r_press;
    logic signed [TEMP_W-1:0]  r_temp;
    logic                      r_probe_ok;

    logic               r_present;
    logic [COUNT_W-1:0] r_fail;
    logic [TIME_W-1:0]  r_last;
    logic [FILL_W-1:0]  r_fill;
    logic [IDX_W-1:0]   r_pos;
    logic               r_jitter;
    logic               r_accepted;
    t_outcome           r_outcome;
    logic               r_probed;
    logic               r_wrote;
    logic               r_was_full;

    logic [PRESS_W-1:0]        r_win [WINDOW_LEN];
    logic [FILL_W-1:0]         r_idx;
    logic                      r_rd_vld;
    logic signed [PRESS_W-1:0] r_rd_data;
    logic                      r_first;
    logic signed [PRESS_W-1:0] r_lo;
    logic signed [PRESS_W-1:0] r_hi;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  w_load;
    logic                  w_out_free;
    logic [TIME_W-1:0]     w_elapsed;
    logic                  w_gap_ok;
    logic [SPREAD_W-1:0]   w_diff;
    logic [SPREAD_W-1:0]   w_spread;
    logic                  w_healthy;
    logic                  w_rd_issue;
    logic [OUT_DATA_W-1:0] w_pack;

    assign w_load     = i_uop.load && i_s_tvalid;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_elapsed  = r_now - r_last;
    assign w_gap_ok   = (w_elapsed >= r_gap);
    assign w_diff     = r_hi - r_lo;
    assign w_spread   = r_first ? '0 : w_diff;
    assign w_healthy  = r_present && (r_fail < r_unhealthy_after) && !r_jitter;
    assign w_rd_issue = i_uop.scan_step && (r_idx < r_fill);

    always_comb begin
        o_flags.in_valid  = i_s_tvalid;
        o_flags.action    = r_action;
        o_flags.present   = r_present;
        o_flags.gap_ok    = w_gap_ok;
        o_flags.read_ok   = r_read_ok;
        o_flags.reprobe   = (r_fail >= r_reprobe_after) && w_gap_ok;
        o_flags.plaus     = r_finite
                            && (r_temp >= r_temp_lo) && (r_temp <= r_temp_hi)
                            && (r_press >= $signed({1'b0, r_press_lo}))
                            && (r_press <= $signed({1'b0, r_press_hi}));
        o_flags.scan_done = (r_idx == r_fill) && !r_rd_vld;
        o_flags.wrote     = r_wrote;
        o_flags.was_full  = r_was_full;
        o_flags.jitter    = r_jitter;
        o_flags.out_free  = w_out_free;
    end

    always_comb begin
        w_pack = '0;
        w_pack[OUT_ACC_BIT]                    = r_accepted;
        w_pack[OUT_OC_LSB +: OUTCOME_W]        = r_outcome;
        w_pack[OUT_PROBED_BIT]                 = r_probed;
        w_pack[OUT_HEALTHY_BIT]                = w_healthy;
        w_pack[OUT_JITTER_BIT]                 = r_jitter;
        w_pack[OUT_SPREAD_LSB +: SPREAD_W]     = w_spread;
        w_pack[OUT_PRESS_LSB +: PRESS_W]       = r_accepted ? r_press : '0;
        w_pack[OUT_TEMP_LSB +: TEMP_W]         = r_accepted ? r_temp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_lo         <= TEMP_LOW_RST;
            r_temp_hi         <= TEMP_HIGH_RST;
            r_press_lo        <= PRESS_LOW_RST;
            r_press_hi        <= PRESS_HIGH_RST;
            r_jit_lim         <= JITTER_LIMIT_RST;
            r_unhealthy_after <= UNHEALTHY_RST;
            r_reprobe_after   <= REPROBE_RST;
            r_gap             <= REPROBE_GAP_RST;
            r_present         <= 1'b0;
            r_fail            <= '0;
            r_last            <= '0;
            r_fill            <= '0;
            r_pos             <= '0;
            r_jitter          <= 1'b0;
            r_accepted        <= 1'b0;
            r_outcome         <= OC_OK;
            r_probed          <= 1'b0;
            r_wrote           <= 1'b0;
            r_was_full        <= 1'b0;
            r_idx             <= '0;
            r_rd_vld          <= 1'b0;
            r_first           <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_TEMP_LOW:        r_temp_lo <= i_cfg_data[TEMP_W-1:0];
                    CFG_TEMP_HIGH:       r_temp_hi <= i_cfg_data[TEMP_W-1:0];
                    CFG_PRESS_LOW:       r_press_lo <= i_cfg_data[LIMIT_P_W-1:0];
                    CFG_PRESS_HIGH:      r_press_hi <= i_cfg_data[LIMIT_P_W-1:0];
                    CFG_JITTER_LIMIT:    r_jit_lim <= i_cfg_data[SPREAD_W-1:0];
                    CFG_UNHEALTHY_AFTER: r_unhealthy_after <= i_cfg_data[COUNT_W-1:0];
                    CFG_REPROBE_AFTER:   r_reprobe_after <= i_cfg_data[COUNT_W-1:0];
                    CFG_REPROBE_GAP:     r_gap <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_load) begin
                r_accepted <= 1'b0;
                r_outcome  <= OC_OK;
                r_probed   <= 1'b0;
                r_wrote    <= 1'b0;
                r_was_full <= 1'b0;
            end

            if (i_uop.start) begin
                r_present <= r_probe_ok;
                r_fail    <= '0;
                r_fill    <= '0;
                r_pos     <= '0;
                r_jitter  <= 1'b0;
                r_last    <= r_now;
                r_probed  <= 1'b1;
                r_outcome <= r_probe_ok ? OC_OK : OC_ABSENT;
            end

            if (i_uop.probe) begin
                r_last    <= r_now;
                r_probed  <= 1'b1;
                r_present <= r_probe_ok;
                if (r_probe_ok) begin
                    r_fail <= '0;
                end
            end

            if (i_uop.bump && (r_fail != FAIL_MAX)) begin
                r_fail <= r_fail + 1'b1;
            end

            if (i_uop.set_oc) begin
                r_outcome <= i_uop.oc;
            end

            if (i_uop.wr) begin
                r_wrote <= 1'b1;
                r_pos   <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                if (r_fill == FILL_FULL) begin
                    r_was_full <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end

            if (i_uop.scan_init) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_first  <= 1'b1;
            end

            if (i_uop.scan_step) begin
                r_rd_vld <= w_rd_issue;
                if (w_rd_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    r_first <= 1'b0;
                end
            end

            if (i_uop.jit_upd) begin
                r_jitter <= (w_spread > r_jit_lim);
            end

            if (i_uop.acc) begin
                r_accepted <= 1'b1;
                r_fail     <= '0;
            end

            if (i_uop.emit && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_action   <= i_s_tuser[IN_ACTION_BIT];
            r_now      <= i_s_tdata[IN_NOW_LSB +: TIME_W];
            r_read_ok  <= i_s_tdata[IN_READ_OK_BIT];
            r_finite   <= i_s_tdata[IN_FINITE_BIT];
            r_press    <= i_s_tdata[IN_PRESS_LSB +: PRESS_W];
            r_temp     <= i_s_tdata[IN_TEMP_LSB +: TEMP_W];
            r_probe_ok <= i_s_tdata[IN_PROBE_BIT];
        end

        if (i_uop.wr) begin
            r_win[r_pos] <= r_press;
        end

        if (w_rd_issue) begin
            r_rd_data <= r_win[r_idx[IDX_W-1:0]];
        end

        if (i_uop.scan_step && r_rd_vld) begin
            if (r_first) begin
                r_lo <= r_rd_data;
                r_hi <= r_rd_data;
            end else begin
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
            end
        end

        if (i_uop.emit && w_out_free) begin
            r_out_data <= w_pack;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/pressure_sensor_health_monitor.sv =====
// Top level of the pressure sensor health monitor: sequencer plus datapath.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | tdata: now_ms, read_ok, values_finite, pressure_in,
//           |           |        temperature_in, probe_ok; tuser: action
//  m_axis   | out       | tdata: sample_accepted, outcome, probe_issued, healthy,
//           |           |        jittery, window_spread, pressure_out, temperature_out
//  cfg      | in        | write enable, register index, write data
//
// One item is worked at a time. The sequencer steps one control word per cycle, unless
// it waits for input or for a free result register, and the spread scan reads one
// window entry per cycle; a start takes the fewest steps, and a re-probe that finds the
// sensor, then a plausible reading with a full window, takes the most.
// The result register lets the next item be taken while a result waits; a stalled
// output holds the sequencer only when a second result is ready.
// Reset restores the limit defaults and clears the sensor state at once.
`default_nettype none

module pressure_sensor_health_monitor
    import psh_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // now_ms[31:0], read_ok, values_finite, pressure_in[23:0], temperature_in[15:0],
    // probe_ok, zero fill
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // action
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // sample_accepted, outcome[2:0], probe_issued, healthy, jittery,
    // window_spread[23:0], pressure_out[23:0], temperature_out[15:0], zero fill
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    t_uop   w_uop;
    t_flags w_flags;
    logic   w_idle;

    psh_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uop   (w_uop),
        .o_idle  (w_idle)
    );

    psh_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_uop      (w_uop),
        .o_flags    (w_flags),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = w_idle;

endmodule

`default_nettype wire

// ===== hdl/psh_chk.sv =====
// Port checker for the pressure sensor health monitor, bound to the top level.
`default_nettype none

module psh_chk
    import psh_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[OUT_ACC_BIT] |->
            o_m_axis_tdata[OUT_PRESS_LSB +: PRESS_W] == '0 &&
            o_m_axis_tdata[OUT_TEMP_LSB +: TEMP_W] == '0)
        else $error("rejected item carries sample values");

    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_ACC_BIT] |->
            o_m_axis_tdata[OUT_OC_LSB +: OUTCOME_W] == OC_OK &&
            !o_m_axis_tdata[OUT_JITTER_BIT])
        else $error("accepted item with a failure code or jitter set");

    a_healthy_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_HEALTHY_BIT] |->
            !o_m_axis_tdata[OUT_JITTER_BIT])
        else $error("healthy reported while jittery");

endmodule

bind pressure_sensor_health_monitor psh_chk u_psh_chk (.*);

`default_nettype wire
